// ===== rtl/core/ght_pkg.sv =====
// ----------------------------------------------------------------------------
// ght_pkg
// shared constants and the request token that walks the slot cell chain
// ----------------------------------------------------------------------------
package ght_pkg;

  localparam int unsigned SLOT_COUNT_DEF = 64;

  localparam int unsigned ADDR_W = 64;
  localparam int unsigned SLOT_W = 16;
  localparam int unsigned GEN_W  = 32;
  localparam int unsigned HNDL_W = SLOT_W + GEN_W;
  localparam int unsigned PAGE_W = 12;
  localparam int unsigned OP_W   = 2;

  localparam int unsigned IN_W  = 328;
  localparam int unsigned OUT_W = 120;

  localparam logic [OP_W-1:0] OP_MAP   = 2'd0;
  localparam logic [OP_W-1:0] OP_UNMAP = 2'd1;
  localparam logic [OP_W-1:0] OP_SYNC  = 2'd2;

  localparam logic [GEN_W-1:0] GEN_RETIRED = '1;

  typedef struct packed {
    logic              valid;
    logic [OP_W-1:0]   op;
    logic              done;
    logic              ok;
    logic              phys_ok;
    logic [SLOT_W-1:0] slot;
    logic [GEN_W-1:0]  gen;
  } tok_t;

endpackage

// ===== rtl/core/ght_cell.sv =====
// ----------------------------------------------------------------------------
// ght_cell
// one table slot: holds its used flag and generation, serves a passing token
// ----------------------------------------------------------------------------
module ght_cell import ght_pkg::*; #(
  parameter int unsigned SlotIdx = 0
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  tok_t tok_i,
  output tok_t tok_o
);

  localparam logic [SLOT_W-1:0] SlotNum = SLOT_W'(SlotIdx + 1);

  logic             used_q, used_d;
  logic [GEN_W-1:0] gen_q, gen_d;
  logic [GEN_W-1:0] gen_inc;
  logic             hdl_ok;
  tok_t             tok_q, tok_d;

  assign gen_inc = gen_q + GEN_W'(1);
  assign hdl_ok  = used_q && (gen_q == tok_i.gen) && (tok_i.gen != '0);

  always_comb begin
    tok_d  = tok_i;
    used_d = used_q;
    gen_d  = gen_q;
    if (tok_i.valid && !tok_i.done) begin
      case (tok_i.op)
        OP_MAP: begin
          if (!used_q && (gen_q != GEN_RETIRED)) begin
            gen_d      = gen_inc;
            used_d     = tok_i.phys_ok;
            tok_d.done = 1'b1;
            tok_d.ok   = tok_i.phys_ok;
            tok_d.gen  = gen_inc;
            tok_d.slot = SlotNum;
          end
        end
        OP_UNMAP, OP_SYNC: begin
          if (tok_i.slot == SlotNum) begin
            tok_d.done = 1'b1;
            tok_d.ok   = hdl_ok;
            if ((tok_i.op == OP_UNMAP) && hdl_ok) begin
              used_d = 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= 1'b0;
      gen_q  <= '0;
      tok_q  <= '0;
    end else begin
      used_q <= used_d;
      gen_q  <= gen_d;
      tok_q  <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

// ===== rtl/core/generational_handle_table_core.sv =====
// ----------------------------------------------------------------------------
// generational_handle_table_core
// generation-tagged mapping handle table built as a chain of slot cells
// ----------------------------------------------------------------------------
// One request is in flight at a time. An accepted request is checked and
// launched as a token into a chain of SLOT_COUNT cells, one per slot, and
// moves one cell per cycle; the first free, unretired cell claims a map,
// and the addressed cell validates an unmap or sync. The token then passes
// through a pending register into the output register; a new request is
// taken only once the pending result has moved on. A finished result waits
// in the output register while the next request is taken. Handles: bits
// 15:0 are slot plus one, bits 47:16 the generation.
module generational_handle_table_core import ght_pkg::*; #(
  parameter int unsigned SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // opcode, virt_addr, region_size, direction, owner_device,
  // translated_phys, handle, zero fill
  input  logic [IN_W-1:0]  s_axis_tdata,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // status, phys_addr, new_handle, zero fill
  output logic [OUT_W-1:0] m_axis_tdata
);

  logic [OP_W-1:0]   in_op;
  logic [ADDR_W-1:0] in_virt, in_size, in_phys, in_handle;
  logic [ADDR_W:0]   end_sum;
  logic              args_ok, in_acc, launch_done;

  logic              busy_q;
  tok_t              tok_q;
  logic [ADDR_W-1:0] phys_q;
  tok_t              pend_q;
  logic              pend_move;

  logic              out_valid_q;
  logic              out_status_q;
  logic [ADDR_W-1:0] out_phys_q;
  logic [HNDL_W-1:0] out_hndl_q;
  logic              res_ok;

  tok_t chain [SLOT_COUNT+1];

  assign in_op     = s_axis_tdata[1:0];
  assign in_virt   = s_axis_tdata[65:2];
  assign in_size   = s_axis_tdata[129:66];
  assign in_phys   = s_axis_tdata[259:196];
  assign in_handle = s_axis_tdata[323:260];

  assign end_sum = {1'b0, in_virt} + {1'b0, in_size};
  assign args_ok = (in_virt != '0) && (in_size != '0) && (in_virt[PAGE_W-1:0] == '0) &&
                   (in_size[PAGE_W-1:0] == '0) && !end_sum[ADDR_W];

  always_comb begin
    case (in_op)
      OP_MAP:            launch_done = !args_ok;
      OP_UNMAP, OP_SYNC: launch_done = 1'b0;
      default:           launch_done = 1'b1;
    endcase
  end

  assign s_axis_tready = !busy_q;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign pend_move     = pend_q.valid && (!out_valid_q || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      tok_q  <= '0;
    end else begin
      tok_q.valid <= in_acc;
      if (in_acc) begin
        busy_q        <= 1'b1;
        tok_q.op      <= in_op;
        tok_q.done    <= launch_done;
        tok_q.ok      <= 1'b0;
        tok_q.phys_ok <= (in_phys != '0);
        tok_q.slot    <= in_handle[SLOT_W-1:0];
        tok_q.gen     <= in_handle[HNDL_W-1:SLOT_W];
      end else if (pend_move) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      phys_q <= in_phys;
    end
  end

  assign chain[0] = tok_q;

  for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
    ght_cell #(
      .SlotIdx(i)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .tok_i (chain[i]),
      .tok_o (chain[i+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (chain[SLOT_COUNT].valid) begin
      pend_q <= chain[SLOT_COUNT];
    end else if (pend_move) begin
      pend_q.valid <= 1'b0;
    end
  end

  assign res_ok = pend_q.done && pend_q.ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pend_move) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pend_move) begin
      out_status_q <= !res_ok;
      if (res_ok && (pend_q.op == OP_MAP)) begin
        out_phys_q <= phys_q;
        out_hndl_q <= {pend_q.gen, pend_q.slot};
      end else begin
        out_phys_q <= '0;
        out_hndl_q <= '0;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_hndl_q, out_phys_q, out_status_q};

  ap_accept_launch : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (tok_q.valid && busy_q))
    else $error("accepted transaction did not enter the cell chain");

  ap_exit_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    chain[SLOT_COUNT].valid |-> (busy_q && !pend_q.valid))
    else $error("token left the chain with no request in flight");

  ap_pend_to_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_move |=> (out_valid_q && !busy_q))
    else $error("pending result not moved to output register");

  ap_no_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_q.valid |-> $past(s_axis_tready))
    else $error("token launched while a request was in flight");

endmodule

// ===== bench/handle_table_checker.sv =====
// ----------------------------------------------------------------------------
// handle_table_checker
// watches both stream channels of the handle table, predicts every reply from
// its own copy of slot occupancy and generations, and compares field by field
// ----------------------------------------------------------------------------
module handle_table_checker import ght_pkg::*; #(
  parameter int unsigned SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_ready_i,
  // opcode, virt_addr, region_size, direction, owner_device,
  // translated_phys, handle, zero fill
  input  logic [IN_W-1:0]  in_data_i,
  input  logic             out_valid_i,
  input  logic             out_ready_i,
  // status, phys_addr, new_handle, zero fill
  input  logic [OUT_W-1:0] out_data_i,
  output int               fail_count_o,
  output int               pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic ST_OK  = 1'b0;
  localparam logic ST_ERR = 1'b1;

  localparam int unsigned VA_LSB    = OP_W;
  localparam int unsigned SIZE_LSB  = VA_LSB + ADDR_W;
  localparam int unsigned PHYS_LSB  = SIZE_LSB + ADDR_W + 2 + ADDR_W;
  localparam int unsigned HANDLE_LSB = PHYS_LSB + ADDR_W;

  localparam int unsigned GRANT_LSB  = 1;
  localparam int unsigned NEW_HANDLE_LSB = GRANT_LSB + ADDR_W;

  typedef struct packed {
    logic              status;
    logic [ADDR_W-1:0] phys;
    logic [HNDL_W-1:0] handle;
  } table_reply_t;

  logic              slot_live [SLOT_COUNT];
  logic [GEN_W-1:0]  slot_gen  [SLOT_COUNT];
  table_reply_t      expected_replies [$];
  int                mismatches = 0;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  function automatic int lookup_slot(logic [ADDR_W-1:0] h);
    int unsigned      s;
    logic [GEN_W-1:0] g;
    s = h[SLOT_W-1:0];
    g = h[HNDL_W-1:SLOT_W];
    if (s == 0 || s > SLOT_COUNT || g == '0) return -1;
    if (!slot_live[s-1] || slot_gen[s-1] != g) return -1;
    return int'(s) - 1;
  endfunction

  function automatic table_reply_t predict_reply(logic [IN_W-1:0] d);
    table_reply_t      r;
    logic [OP_W-1:0]   op;
    logic [ADDR_W-1:0] va, sz, phys, hdl;
    logic [ADDR_W:0]   span_end;
    logic              claimed;
    int                idx;
    op   = d[OP_W-1:0];
    va   = d[VA_LSB +: ADDR_W];
    sz   = d[SIZE_LSB +: ADDR_W];
    phys = d[PHYS_LSB +: ADDR_W];
    hdl  = d[HANDLE_LSB +: ADDR_W];
    r = '{status: ST_ERR, phys: '0, handle: '0};
    span_end = {1'b0, va} + {1'b0, sz};
    case (op)
      OP_MAP: begin
        if (va != '0 && sz != '0 && va[PAGE_W-1:0] == '0 && sz[PAGE_W-1:0] == '0 &&
            !span_end[ADDR_W]) begin
          claimed = 1'b0;
          for (int i = 0; i < SLOT_COUNT; i++) begin
            if (!claimed && !slot_live[i] && slot_gen[i] != GEN_RETIRED) begin
              claimed = 1'b1;
              slot_gen[i] = slot_gen[i] + 1'b1;
              // failed translation burns the generation but leaves the slot free
              if (phys != '0) begin
                slot_live[i] = 1'b1;
                r.status = ST_OK;
                r.phys   = phys;
                r.handle = {slot_gen[i], SLOT_W'(i + 1)};
              end
            end
          end
        end
      end
      OP_UNMAP: begin
        idx = lookup_slot(hdl);
        if (idx >= 0) begin
          slot_live[idx] = 1'b0;
          r.status = ST_OK;
        end
      end
      OP_SYNC: begin
        if (lookup_slot(hdl) >= 0) r.status = ST_OK;
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    table_reply_t want;
    table_reply_t got;
    if (!rst_ni) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        slot_live[i] = 1'b0;
        slot_gen[i]  = '0;
      end
      expected_replies.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        got.status = out_data_i[0];
        got.phys   = out_data_i[GRANT_LSB +: ADDR_W];
        got.handle = out_data_i[NEW_HANDLE_LSB +: HNDL_W];
        if (expected_replies.size() == 0) begin
          $error("reply transaction with none outstanding: status %0d phys %h handle %h",
                 got.status, got.phys, got.handle);
          mismatches++;
        end else begin
          want = expected_replies.pop_front();
          if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            mismatches++;
          end
          if (got.phys !== want.phys) begin
            $error("phys_addr: expected %h, actual %h", want.phys, got.phys);
            mismatches++;
          end
          if (got.handle !== want.handle) begin
            $error("new_handle: expected %h, actual %h", want.handle, got.handle);
            mismatches++;
          end
        end
      end
      if (in_valid_i && in_ready_i) expected_replies.push_back(predict_reply(in_data_i));
    end
    fail_count_o <= mismatches;
    pending_o    <= expected_replies.size();
  end

endmodule

// ===== bench/generational_handle_table_core_test.sv =====
// ----------------------------------------------------------------------------
// generational_handle_table_core_test
// drives map, unmap, sync and invalid-opcode requests into the handle table
// with random idling on both channels, a long output hold-off and a full
// drain pause; reply checking is done by handle_table_checker
// ----------------------------------------------------------------------------
module generational_handle_table_core_test import ght_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          CLK_PERIOD     = 4;
  localparam int          RANDOM_ITEMS   = 1000;
  localparam int          QUIET_TAIL     = 150;
  localparam int          HOLD_AT_ITEM   = 300;
  localparam int          HOLD_CYCLES    = 600;
  localparam int          PAUSE_AT_ITEM  = 600;
  localparam int          DRAIN_CYCLES   = 2 * (SLOT_COUNT_DEF + 3);
  localparam int          TIMEOUT_NS     = 4_000_000;
  localparam logic [OP_W-1:0] OP_BAD     = 2'd3;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;

  int fail_count;
  int pending;
  int sent_items = 0;
  bit quiet_phase = 1'b0;

  logic [HNDL_W-1:0] live_handles  [$];
  logic [HNDL_W-1:0] stale_handles [$];

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  generational_handle_table_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  handle_table_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_i  (s_axis_tready),
    .in_data_i   (s_axis_tdata),
    .out_valid_i (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_i  (m_axis_tdata),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // harvest granted handles so later requests can address live mappings
  always @(negedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready &&
        m_axis_tdata[1 + ADDR_W +: HNDL_W] != '0)
      live_handles.push_back(m_axis_tdata[1 + ADDR_W +: HNDL_W]);
  end

  function automatic logic [ADDR_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [IN_W-1:0] pack_req(
    logic [OP_W-1:0] op, logic [ADDR_W-1:0] va, logic [ADDR_W-1:0] sz, logic [1:0] dir,
    logic [ADDR_W-1:0] owner, logic [ADDR_W-1:0] phys, logic [ADDR_W-1:0] hdl
  );
    return {4'b0, hdl, phys, owner, dir, sz, va, op};
  endfunction

  function automatic logic [IN_W-1:0] handle_req(logic [OP_W-1:0] op, logic [ADDR_W-1:0] hdl);
    return pack_req(op, rand64(), rand64(), 2'($urandom), rand64(), rand64(), hdl);
  endfunction

  function automatic logic [IN_W-1:0] random_request();
    int unsigned       pick;
    int unsigned       k;
    logic [ADDR_W-1:0] va, sz, phys;
    logic [HNDL_W-1:0] h;
    pick = $urandom_range(0, 99);
    va   = rand64();
    sz   = rand64();
    phys = rand64();
    if (pick < 45) begin
      va[PAGE_W-1:0] = '0;
      if (va == '0) va = 64'h1000;
      sz = ADDR_W'($urandom_range(1, 255)) << PAGE_W;
      if ($urandom_range(0, 15) == 0) begin
        sz = rand64();
        sz[PAGE_W-1:0] = '0;
      end
      if ($urandom_range(0, 19) == 0) phys = '0;
      return pack_req(OP_MAP, va, sz, 2'($urandom), rand64(), phys, rand64());
    end else if (pick < 78) begin
      if (live_handles.size() == 0) return handle_req(OP_SYNC, rand64());
      k = $urandom_range(0, live_handles.size() - 1);
      h = live_handles[k];
      if (pick < 65) begin
        live_handles.delete(k);
        stale_handles.push_back(h);
        if (stale_handles.size() > 64) void'(stale_handles.pop_front());
        return handle_req(OP_UNMAP, {16'($urandom), h});
      end
      return handle_req(OP_SYNC, {16'($urandom), h});
    end else if (pick < 86) begin
      if (stale_handles.size() == 0) return handle_req(OP_UNMAP, rand64());
      h = stale_handles[$urandom_range(0, stale_handles.size() - 1)];
      return handle_req($urandom_range(0, 1) ? OP_UNMAP : OP_SYNC, {16'($urandom), h});
    end else if (pick < 93) begin
      case ($urandom_range(0, 3))
        0: va = '0;
        1: sz = '0;
        2: begin
          va = {4'hf, va[ADDR_W-5:0]};
          va[PAGE_W-1:0] = '0;
          sz = {1'b1, sz[ADDR_W-2:0]};
          sz[PAGE_W-1:0] = '0;
        end
        default: ;
      endcase
      return pack_req(OP_MAP, va, sz, 2'($urandom), rand64(), phys, rand64());
    end
    return pack_req(OP_W'($urandom), va, sz, 2'($urandom), rand64(), phys, rand64());
  endfunction

  task automatic offer(input logic [IN_W-1:0] d);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    do @(posedge clk_i); while (!s_axis_tready);
    sent_items++;
    if (!quiet_phase && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  initial begin
    #(TIMEOUT_NS);
    $display("FAIL");
    $finish;
  end

  initial begin : receiver
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (sent_items >= HOLD_AT_ITEM && sent_items < HOLD_AT_ITEM + 10) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        m_axis_tready <= 1'b1;
        repeat (20) @(posedge clk_i);
      end else if (!quiet_phase && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 40)) @(posedge clk_i);
      end
    end
  end

  initial begin : sender
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // argument checks
    offer(pack_req(OP_MAP, '0, 64'h1000, 2'd0, '0, 64'h5000, '0));
    offer(pack_req(OP_MAP, 64'h1000, '0, 2'd1, '0, 64'h5000, '0));
    offer(pack_req(OP_MAP, 64'h1001, 64'h1000, 2'd2, '0, 64'h5000, '0));
    offer(pack_req(OP_MAP, 64'h1000, 64'h1800, 2'd3, '0, 64'h5000, '0));
    offer(pack_req(OP_MAP, 64'hffff_ffff_ffff_f000, 64'h1000, 2'd0, '0, 64'h5000, '0));
    // largest span that does not wrap, all-ones payload
    offer(pack_req(OP_MAP, 64'h8000_0000_0000_0000, 64'h7fff_ffff_ffff_f000, 2'd3, '1, '1, '1));
    // failed translation consumes a generation
    offer(pack_req(OP_MAP, 64'h2000, 64'h1000, 2'd1, 64'h7, '0, '0));
    offer(pack_req(OP_MAP, 64'h1000, 64'h1000, 2'd0, 64'h8, 64'h1, '0));
    // handle checks
    offer(handle_req(OP_SYNC, '0));
    offer(handle_req(OP_SYNC, 64'h0000_0000_0001_0041));
    offer(handle_req(OP_SYNC, 64'h0000_0000_0000_0001));
    offer(handle_req(OP_SYNC, 64'h0000_0000_0001_0003));
    offer(handle_req(OP_SYNC, 64'h0000_0000_0001_0002));
    offer(handle_req(OP_SYNC, 64'hffff_0000_0001_0001));
    offer(handle_req(OP_BAD, 64'h0000_0000_0001_0001));
    offer(handle_req(OP_UNMAP, 64'h0000_0000_0002_0002));
    offer(handle_req(OP_UNMAP, 64'h0000_0000_0002_0002));
    offer(handle_req(OP_SYNC, 64'h0000_0000_0002_0002));
    offer(handle_req(OP_UNMAP, 64'h0000_0000_0001_ffff));
    offer(pack_req(OP_MAP, 64'h3000, 64'h2000, 2'd2, 64'h9, 64'habc000, '0));
    offer(handle_req(OP_UNMAP, 64'h1234_0000_0001_0001));

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == PAUSE_AT_ITEM) settle();
      if (n == RANDOM_ITEMS - QUIET_TAIL) quiet_phase = 1'b1;
      offer(random_request());
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/ght_pkg.sv
rtl/core/ght_cell.sv
rtl/core/generational_handle_table_core.sv
bench/handle_table_checker.sv
bench/generational_handle_table_core_test.sv
